FILE: design/nta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int RSSI_W    = 9;
    localparam int SNR_W     = 8;
    localparam int LIMIT_W   = 24;
    localparam int DENSITY_W = 12;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 4;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    localparam logic [LIMIT_W-1:0] STALE_RESET = 24'd180000;

    // Moving average weights, 0.3 and 0.7 in steps of 1/256
    localparam int DENS_PROD_W = 19;
    localparam int DENS_SUM_W  = 15;
    localparam logic [DENS_PROD_W-1:0] DENS_OLD_WEIGHT = 19'd77;
    localparam logic [DENS_SUM_W-1:0]  DENS_NEW_WEIGHT = 15'd179;
    localparam logic [DENS_SUM_W-1:0]  DENSITY_MAX     = 15'd4095;

    localparam logic ACT_HEARD = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEARD_SCAN,
        ST_HEARD_WRITE,
        ST_TICK_SCAN,
        ST_DENSITY,
        ST_DONE
    } nta_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        logic [RSSI_W-1:0] rssi;
        logic [SNR_W-1:0]  snr;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] age;
        logic              older;
        logic              stale;
    } age_res_t;

endpackage : nta_pkg
`default_nettype wire

FILE: design/nta_age_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nta_age_unit
// Shared age unit: one modulo-2^32 subtract and two compares per cycle.
// ----------------------------------------------------------------------------
module nta_age_unit
    import nta_pkg::*;
(
    input  wire logic [TIME_W-1:0]  now,
    input  wire logic [TIME_W-1:0]  stamp,
    input  wire logic [TIME_W-1:0]  worst,
    input  wire logic [LIMIT_W-1:0] limit,
    output age_res_t                res
);

    logic [TIME_W-1:0] age;

    assign age = now - stamp;

    always_comb begin
        res.age   = age;
        res.older = (age > worst);
        res.stale = (age >= TIME_W'(limit));
    end

endmodule : nta_age_unit
`default_nettype wire

FILE: design/neighbor_table_aging.sv
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_table_aging
// Packed table of heard radio neighbors with eviction of the oldest entry,
// removal of stale entries on a tick and a moving average of the live count.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           contents
//  s_        in    s_tvalid/s_tready   heard request or tick request
//  m_        out   m_tvalid/m_tready   slot, evicted, peer count, density
//  cfg_      in    cfg_valid/cfg_ready stale limit in ms
//
//  Steps: a tick walks all live entries, then updates the density; a heard
//  request walks entries up to a match or the end of the live entries, then
//  writes its slot; both then load the result into the output register.
//  The shared age unit walks one table entry per cycle.
//  Reset: the table empties (live count cleared), density returns to zero and
//  the stale limit to 180000 ms.
//  Stalls: the result sits in an output register; a finished request waits
//  in its last step while an earlier result is still not taken.
//
module neighbor_table_aging
    import nta_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [15:0] peer_id, [47:16] now_ms, [56:48] rssi, [64:57] snr_quarter_db
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // [0] action
    input  wire logic                 s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] slot, [3] evicted, [7:4] peer_count, [19:8] density
    output logic [M_DATA_W-1:0]       m_tdata,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LIMIT_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    nta_state_t           state_reg, state_next;

    logic                 act_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [RSSI_W-1:0]    rssi_reg;
    logic [SNR_W-1:0]     snr_reg;

    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [TIME_W-1:0]    worst_reg, worst_next;
    logic [IDX_W-1:0]     target_reg, target_next;
    logic                 evict_reg, evict_next;
    logic [DENSITY_W-1:0] density_reg, density_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Table payload; valid entries are slots 0 .. count_reg-1
    entry_t               entry_reg [TABLE_ENTRIES];

    logic                 ent_we;
    logic [IDX_W-1:0]     ent_waddr;
    entry_t               ent_wdata;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                 s_accept;
    logic                 out_free;
    logic                 scan_in;
    logic                 id_match;
    entry_t               rd_entry;
    age_res_t             age_res;

    logic [DENS_PROD_W-1:0] dens_prod;
    logic [DENS_SUM_W-1:0]  dens_sum;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign scan_in  = (scan_reg < count_reg);
    assign rd_entry = entry_reg[scan_reg[IDX_W-1:0]];
    assign id_match = (rd_entry.id == id_reg);

    nta_age_unit u_age (
        .now   (now_reg),
        .stamp (rd_entry.stamp),
        .worst (worst_reg),
        .limit (limit_reg),
        .res   (age_res)
    );

    // density = (77*density + 179*count*256) >> 8; the second term is a
    // whole multiple of 256, so only the first one is shifted.
    assign dens_prod = DENS_PROD_W'(density_reg) * DENS_OLD_WEIGHT;
    assign dens_sum  = DENS_SUM_W'(dens_prod[DENS_PROD_W-1:8])
                     + DENS_SUM_W'(count_reg) * DENS_NEW_WEIGHT;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == ACT_TICK) ? ST_TICK_SCAN : ST_HEARD_SCAN;
                end
            end
            ST_HEARD_SCAN: begin
                if (!scan_in || id_match) begin
                    state_next = ST_HEARD_WRITE;
                end
            end
            ST_HEARD_WRITE: state_next = ST_DONE;
            ST_TICK_SCAN: begin
                if (!scan_in) begin
                    state_next = ST_DENSITY;
                end
            end
            ST_DENSITY: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb begin
        s_tready      = 1'b0;
        scan_next     = scan_reg;
        wr_next       = wr_reg;
        count_next    = count_reg;
        victim_next   = victim_reg;
        worst_next    = worst_reg;
        target_next   = target_reg;
        evict_next    = evict_reg;
        density_next  = density_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ent_we        = 1'b0;
        ent_waddr     = target_reg;
        ent_wdata     = '{id: id_reg, stamp: now_reg, rssi: rssi_reg, snr: snr_reg};

        // Drop the result once the sink takes it
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    scan_next   = '0;
                    wr_next     = '0;
                    worst_next  = '0;
                    victim_next = '0;
                    target_next = '0;
                    evict_next  = 1'b0;
                end
            end
            ST_HEARD_SCAN: begin
                if (!scan_in) begin
                    // No match: first empty slot, else the oldest entry
                    if (count_reg == CNT_W'(TABLE_ENTRIES)) begin
                        evict_next  = 1'b1;
                        target_next = victim_reg;
                    end else begin
                        target_next = IDX_W'(count_reg);
                    end
                end else if (id_match) begin
                    target_next = scan_reg[IDX_W-1:0];
                end else begin
                    // Strict compare keeps the lowest slot on a tie
                    if (scan_reg == '0 || age_res.older) begin
                        victim_next = scan_reg[IDX_W-1:0];
                        worst_next  = age_res.age;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_HEARD_WRITE: begin
                ent_we    = 1'b1;
                ent_waddr = target_reg;
                if (CNT_W'(target_reg) == count_reg) begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_TICK_SCAN: begin
                if (scan_in) begin
                    // Keep a live entry by moving it down to the write point
                    if (!age_res.stale) begin
                        ent_we    = 1'b1;
                        ent_waddr = wr_reg[IDX_W-1:0];
                        ent_wdata = rd_entry;
                        wr_next   = wr_reg + 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                end else begin
                    count_next = wr_reg;
                end
            end
            ST_DENSITY: begin
                density_next = (dens_sum > DENSITY_MAX) ? '1 : dens_sum[DENSITY_W-1:0];
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({density_reg, COUNT_W'(count_reg),
                                               evict_reg, SLOT_W'(target_reg)});
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_reg     <= '0;
            wr_reg       <= '0;
            count_reg    <= '0;
            victim_reg   <= '0;
            worst_reg    <= '0;
            target_reg   <= '0;
            evict_reg    <= 1'b0;
            density_reg  <= '0;
            limit_reg    <= STALE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            wr_reg       <= wr_next;
            count_reg    <= count_next;
            victim_reg   <= victim_next;
            worst_reg    <= worst_next;
            target_reg   <= target_next;
            evict_reg    <= evict_next;
            density_reg  <= density_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_accept) begin
            act_reg  <= s_tuser;
            id_reg   <= s_tdata[15:0];
            now_reg  <= s_tdata[47:16];
            rssi_reg <= s_tdata[56:48];
            snr_reg  <= s_tdata[64:57];
        end
        if (ent_we) begin
            entry_reg[ent_waddr] <= ent_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("live count above table size");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request accepted while previous one in progress");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside final step");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_SCAN) |-> (wr_reg <= scan_reg))
        else $error("compaction write point passed read point");

    a_heard_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HEARD_WRITE) |=> (count_reg != '0))
        else $error("table empty after heard write");

    a_tick_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HEARD_SCAN) |-> (act_reg == ACT_HEARD))
        else $error("tick request walking heard path");

endmodule : neighbor_table_aging
`default_nettype wire

FILE: sim/tb_neighbor_table_aging.sv
// ----------------------------------------------------------------------------
// tb_neighbor_table_aging
// Self-checking bench for the neighbor table: a directed warm-up (extreme
// fields, id refresh, eviction ties, exact stale boundary, time wrap) and then
// random traffic from a small set of neighbors under several stale limits.
// Every result is checked field by field against an in-bench model of the
// table, the stale limit and the density average.
// ----------------------------------------------------------------------------
module tb_neighbor_table_aging;
    import nta_pkg::*;

    typedef struct {
        logic              action;
        logic [ID_W-1:0]   peer_id;
        logic [TIME_W-1:0] now_ms;
        logic [RSSI_W-1:0] rssi;
        logic [SNR_W-1:0]  snr;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic                 evicted;
        logic [COUNT_W-1:0]   peer_count;
        logic [DENSITY_W-1:0] density;
    } report_t;

    // receiver stall modes
    localparam int RX_FREE  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_STALL = 2;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [15:0] peer_id, [47:16] now_ms, [56:48] rssi, [64:57] snr_quarter_db
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    // [0] action
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] slot, [3] evicted, [7:4] peer_count, [19:8] density
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data  = '0;

    neighbor_table_aging dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Table model
    logic                 tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
    logic [ID_W-1:0]      tbl_id    [TABLE_ENTRIES];
    logic [TIME_W-1:0]    tbl_stamp [TABLE_ENTRIES];
    logic [RSSI_W-1:0]    tbl_rssi  [TABLE_ENTRIES];
    logic [SNR_W-1:0]     tbl_snr   [TABLE_ENTRIES];
    logic [DENSITY_W-1:0] density_avg = '0;
    logic [LIMIT_W-1:0]   stale_limit = STALE_RESET;

    request_t request_queue [$];
    report_t  awaited_reports [$];
    int       n_issued   = 0;
    int       n_reported = 0;
    int       n_fail     = 0;

    logic [TIME_W-1:0] clock_ms = '0;
    logic [ID_W-1:0]   peer_pool [16];
    int                pool_size = 1;

    // Apply one request to the table model and return the report it yields.
    function automatic report_t apply_request(input request_t rq);
        report_t           rep;
        int                target;
        int                victim;
        int                wr;
        int unsigned       acc;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] worst;
        logic              have;
        rep    = '0;
        target = -1;
        victim = 0;
        worst  = '0;
        have   = 1'b0;
        if (rq.action == ACT_HEARD) begin
            // first free or matching slot; otherwise the oldest, lowest on a tie
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (target < 0) begin
                    if (!tbl_valid[i] || tbl_id[i] == rq.peer_id) begin
                        target = i;
                    end else begin
                        age = rq.now_ms - tbl_stamp[i];
                        if (!have || age > worst) begin
                            worst  = age;
                            victim = i;
                            have   = 1'b1;
                        end
                    end
                end
            end
            if (target < 0) begin
                target      = victim;
                rep.evicted = 1'b1;
            end
            tbl_valid[target] = 1'b1;
            tbl_id[target]    = rq.peer_id;
            tbl_stamp[target] = rq.now_ms;
            tbl_rssi[target]  = rq.rssi;
            tbl_snr[target]   = rq.snr;
            rep.slot          = target[SLOT_W-1:0];
        end else begin
            // drop stale entries, keep the survivors packed in order
            wr = 0;
            for (int rd = 0; rd < TABLE_ENTRIES; rd++) begin
                age = rq.now_ms - tbl_stamp[rd];
                if (tbl_valid[rd] && age < TIME_W'(stale_limit)) begin
                    tbl_valid[wr] = 1'b1;
                    tbl_id[wr]    = tbl_id[rd];
                    tbl_stamp[wr] = tbl_stamp[rd];
                    tbl_rssi[wr]  = tbl_rssi[rd];
                    tbl_snr[wr]   = tbl_snr[rd];
                    wr++;
                end
            end
            for (int rd = wr; rd < TABLE_ENTRIES; rd++) begin
                tbl_valid[rd] = 1'b0;
            end
            acc         = (77 * int'(density_avg) + 179 * wr * 256) >> 8;
            density_avg = acc[DENSITY_W-1:0];
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rep.peer_count += COUNT_W'(tbl_valid[i]);
        end
        rep.density = density_avg;
        return rep;
    endfunction

    task automatic queue_request(input logic act, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] now,
                                 input logic [RSSI_W-1:0] rssi,
                                 input logic [SNR_W-1:0] snr);
        request_t rq;
        rq.action  = act;
        rq.peer_id = id;
        rq.now_ms  = now;
        rq.rssi    = rssi;
        rq.snr     = snr;
        request_queue.push_back(rq);
        n_issued++;
    endtask

    task automatic wait_drained();
        while (n_reported != n_issued) @(posedge aclk);
    endtask

    // Write the stale limit; only called with the table idle.
    task automatic write_stale_limit(input logic [LIMIT_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        stale_limit  = value;
    endtask

    // Mostly a handful of neighbors heard with time moving forward, ticks in
    // between; a tenth of the requests are heard items from strangers at
    // arbitrary times.
    task automatic run_traffic(input int n_items);
        int          sel;
        int unsigned span;
        pool_size = $urandom_range(3, 14);
        for (int i = 0; i < pool_size; i++) begin
            peer_pool[i] = ID_W'($urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
            clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 64))
                       - TIME_W'(stale_limit >> 1);
        end
        span = stale_limit / 6 + 1;
        for (int k = 0; k < n_items; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: clock_ms += TIME_W'($urandom_range(0, span));
                6, 7: ;
                8: clock_ms += TIME_W'(stale_limit);
                default: clock_ms += TIME_W'($urandom);
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                queue_request(ACT_HEARD, peer_pool[$urandom_range(0, pool_size - 1)],
                              clock_ms, RSSI_W'(0 - int'($urandom_range(0, 256))),
                              SNR_W'($urandom));
            end else if (sel < 90) begin
                queue_request(ACT_TICK, ID_W'($urandom), clock_ms,
                              RSSI_W'($urandom), SNR_W'($urandom));
            end else begin
                queue_request(ACT_HEARD, ID_W'($urandom), TIME_W'($urandom),
                              RSSI_W'(0 - int'($urandom_range(0, 256))),
                              SNR_W'($urandom));
            end
        end
        wait_drained();
    endtask

    // Sender: bursts of random length separated by random gaps.
    request_t shown_req;
    int       burst_left = 1;
    int       gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_reports.push_back(apply_request(shown_req));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    shown_req = request_queue.pop_front();
                    s_tdata   <= {7'd0, shown_req.snr, shown_req.rssi,
                                  shown_req.now_ms, shown_req.peer_id};
                    s_tuser   <= shown_req.action;
                    s_tvalid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int expv, input int gotv);
        if (expv != gotv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, gotv);
            n_fail++;
        end
    endtask

    // Receiver: stall mode is picked anew whenever rx_cycle wraps to zero.
    int          rx_mode  = RX_FREE;
    int          rx_hold  = 0;
    logic [6:0]  rx_cycle = '0;
    report_t     want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                n_fail++;
            end else begin
                want = awaited_reports.pop_front();
                if ($isunknown(m_tdata[19:0])) begin
                    $display("%0t: unknown bits, expected %h, got %h",
                             $time, want, m_tdata[19:0]);
                    n_fail++;
                end else begin
                    check_field("slot", want.slot, m_tdata[2:0]);
                    check_field("evicted", want.evicted, m_tdata[3]);
                    check_field("peer_count", want.peer_count, m_tdata[7:4]);
                    check_field("density", want.density, m_tdata[19:8]);
                end
            end
            n_reported++;
        end
        rx_cycle <= rx_cycle + 7'd1;
        if (rx_cycle == '0) begin
            rx_mode = $urandom_range(RX_FREE, RX_STALL);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_STALL: begin
                    if ($urandom_range(0, 7) == 0) begin
                        rx_hold = $urandom_range(1, 20);
                    end
                    m_tready <= 1'b1;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Default limit: fill with tied stamps, refresh, evict, age out.
        queue_request(ACT_TICK,  16'h0000, 32'd0,    9'h000, 8'h00);
        queue_request(ACT_HEARD, 16'h0000, 32'd1000, 9'h100, 8'h80);
        queue_request(ACT_HEARD, 16'hFFFF, 32'd1000, 9'h000, 8'h7F);
        queue_request(ACT_HEARD, 16'h0001, 32'd1000, 9'h1FF, 8'hFF);
        queue_request(ACT_HEARD, 16'h8000, 32'd1000, 9'h180, 8'h00);
        queue_request(ACT_HEARD, 16'h7FFF, 32'd1000, 9'h1AB, 8'h55);
        queue_request(ACT_HEARD, 16'h5555, 32'd1000, 9'h1D4, 8'hAA);
        queue_request(ACT_HEARD, 16'hAAAA, 32'd1000, 9'h1C0, 8'h0F);
        queue_request(ACT_HEARD, 16'h00FF, 32'd1000, 9'h1F0, 8'hF0);
        // refresh in place, then two evictions among equally old entries
        queue_request(ACT_HEARD, 16'hFFFF, 32'd2000, 9'h1E0, 8'h10);
        queue_request(ACT_HEARD, 16'h1234, 32'd3000, 9'h1FE, 8'h01);
        queue_request(ACT_HEARD, 16'h4321, 32'd3000, 9'h101, 8'h81);
        // age exactly at the limit drops, one below stays
        queue_request(ACT_TICK,  16'hFFFF, 32'd181000, 9'h1FF, 8'hFF);
        queue_request(ACT_TICK,  16'h0000, 32'd182999, 9'h000, 8'h00);
        // time wrap
        queue_request(ACT_HEARD, 16'hBEEF, 32'hFFFF_FFF0, 9'h1C8, 8'h3C);
        queue_request(ACT_TICK,  16'h0000, 32'h0000_0010, 9'h000, 8'h00);
        queue_request(ACT_TICK,  16'h0000, 32'h0000_0011, 9'h000, 8'h00);
        wait_drained();
        clock_ms = 32'h0000_0011;
        run_traffic(160);

        // Zero limit: any tick empties the table.
        write_stale_limit(24'd0);
        queue_request(ACT_HEARD, 16'h0042, clock_ms, 9'h1F6, 8'h20);
        queue_request(ACT_HEARD, 16'h0043, clock_ms, 9'h1EC, 8'hE0);
        queue_request(ACT_TICK,  16'h0000, clock_ms, 9'h000, 8'h00);
        wait_drained();
        run_traffic(140);

        write_stale_limit(24'd1);
        run_traffic(160);
        write_stale_limit(24'hFF_FFFF);
        run_traffic(160);
        write_stale_limit(LIMIT_W'($urandom_range(2, 4000)));
        run_traffic(160);
        write_stale_limit(LIMIT_W'($urandom_range(4001, 24'hFF_FFFE)));
        run_traffic(140);
        write_stale_limit(STALE_RESET);
        run_traffic(210);

        wait_drained();
        repeat (16) @(posedge aclk);
        if (n_fail == 0 && awaited_reports.size() == 0) begin
            $display("PASS neighbor_table_aging");
        end else begin
            $display("FAIL neighbor_table_aging");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL neighbor_table_aging");
        $finish;
    end

endmodule

FILE: neighbor_table_aging.f
design/nta_pkg.sv
design/nta_age_unit.sv
design/neighbor_table_aging.sv
sim/tb_neighbor_table_aging.sv
